[hdl/rfkp_pkg.sv]
// Shared types, event codes and key code table for the remote key press/hold/repeat block.
package rfkp_pkg;

  typedef logic [1:0] key_id_t;

  typedef enum logic [1:0] {
    EVT_PRESS   = 2'd0,
    EVT_HOLD    = 2'd1,
    EVT_RELEASE = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    CFG_SUSTAIN    = 2'd0,
    CFG_HOLD_START = 2'd1,
    CFG_REPEAT     = 2'd2
  } cfg_index_t;

  localparam int unsigned SUSTAIN_W = 8;
  localparam int unsigned HELD_W    = 10;
  localparam int unsigned REPEAT_W  = 8;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [SUSTAIN_W-1:0] SUSTAIN_RESET    = 8'd30;
  localparam logic [HELD_W-1:0]    HOLD_START_RESET = 10'd150;
  localparam logic [REPEAT_W-1:0]  REPEAT_RESET     = 8'd30;

  typedef struct packed {
    logic [SUSTAIN_W-1:0] sustain_ticks;
    logic [HELD_W-1:0]    hold_thresh;
    logic [REPEAT_W-1:0]  repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic    code_valid;
    logic [7:0] rf_code;
  } tick_t;

  typedef struct packed {
    logic        valid;
    key_id_t     key_id;
    event_kind_t event_kind;
  } result_t;

  typedef struct packed {
    logic    hit;
    key_id_t key;
  } key_map_t;

  // Remote code byte to key; codes outside the table map to no key.
  function automatic key_map_t map_code(input logic [7:0] code);
    key_map_t m;
    m.hit = 1'b1;
    m.key = 2'd0;
    case (code)
      8'h04, 8'h2E: m.key = 2'd0;
      8'h05, 8'h4C: m.key = 2'd1;
      8'h1A, 8'h5B: m.key = 2'd2;
      8'h01, 8'h3D: m.key = 2'd3;
      default:      m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[hdl/rfkp_in_stage.sv]
// Input register for tick transactions.
module rfkp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rfkp_pkg::tick_t tick_in,
  input  logic           advance,
  output logic           held_valid,
  output rfkp_pkg::tick_t tick_held
);
  import rfkp_pkg::*;

  logic   vld;
  tick_t  data;

  assign in_ready   = !vld || advance;
  assign held_valid = vld;
  assign tick_held  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= tick_in;
    end
  end

endmodule

[hdl/rfkp_tracker.sv]
// Key state tracker: press latch, sustain, held time and repeat counters.
module rfkp_tracker (
  input  logic             clk,
  input  logic             rst,
  input  rfkp_pkg::cfg_t   cfg,
  input  logic             step,
  input  rfkp_pkg::tick_t  tick,
  output rfkp_pkg::result_t result
);
  import rfkp_pkg::*;

  logic                 key_active, key_active_next;
  key_id_t              active_key, active_key_next;
  logic [SUSTAIN_W-1:0] sustain_left, sustain_left_next;
  logic [HELD_W-1:0]    held_ticks, held_ticks_next;
  logic [REPEAT_W-1:0]  repeat_count, repeat_count_next;

  key_map_t m;
  logic     mapped, pressed;

  always_comb begin
    m       = map_code(tick.rf_code);
    mapped  = tick.code_valid && m.hit;
    pressed = mapped && !key_active;

    key_active_next   = key_active || mapped;
    active_key_next   = pressed ? m.key : active_key;
    held_ticks_next   = pressed ? '0 : held_ticks;
    repeat_count_next = pressed ? '0 : repeat_count;
    sustain_left_next = mapped ? cfg.sustain_ticks : sustain_left;

    result.valid      = 1'b0;
    result.key_id     = active_key_next;
    result.event_kind = EVT_PRESS;

    if (key_active_next) begin
      if (sustain_left_next != '0) begin
        sustain_left_next = sustain_left_next - 1'b1;
        // Held time stops at the threshold rather than wrapping.
        if (held_ticks_next < cfg.hold_thresh) begin
          held_ticks_next = held_ticks_next + 1'b1;
        end
        if (held_ticks_next >= cfg.hold_thresh) begin
          repeat_count_next = repeat_count_next + 1'b1;
          if (repeat_count_next >= cfg.repeat_ticks) begin
            repeat_count_next = '0;
            result.valid      = 1'b1;
            result.event_kind = EVT_HOLD;
          end
        end
      end else if (!pressed) begin
        key_active_next   = 1'b0;
        held_ticks_next   = '0;
        result.valid      = 1'b1;
        result.event_kind = EVT_RELEASE;
      end
      // A press outranks a hold event in the same tick.
      if (pressed) begin
        result.valid      = 1'b1;
        result.event_kind = EVT_PRESS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_active   <= 1'b0;
      active_key   <= '0;
      sustain_left <= '0;
      held_ticks   <= '0;
      repeat_count <= '0;
    end else if (step) begin
      key_active   <= key_active_next;
      active_key   <= active_key_next;
      sustain_left <= sustain_left_next;
      held_ticks   <= held_ticks_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

[hdl/rfkp_out_stage.sv]
// Result register holding one event transaction until the receiver takes it.
module rfkp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rfkp_pkg::result_t result,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              free,
  output rfkp_pkg::key_id_t key_id,
  output logic [1:0]        event_kind
);
  import rfkp_pkg::*;

  logic        vld;
  key_id_t     key;
  event_kind_t kind;

  assign free       = !vld || out_ready;
  assign out_valid  = vld;
  assign key_id     = key;
  assign event_kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= result.valid;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
    if (load && result.valid) begin
      key  <= result.key_id;
      kind <= result.event_kind;
    end
  end

endmodule

[hdl/rf_key_press_hold_repeat_top.sv]
// Top level of the remote key press, hold-repeat and release detector.
//
// Each input transaction is one 10 ms tick carrying code_valid and the raw
// rf_code byte. Eight code values map to four keys (up, down, on/off, mode).
// At most one event transaction per tick leaves on the output channel:
// press, hold repeat or release, tagged with the latched key. Both channels
// use valid/ready; a transaction moves when both are high.
//
// A tick sits in the input register until the result register is free; the
// tracker then updates its counters and loads the result register, which
// presents its event. Throughput is one tick per cycle while the result
// register is free, set by the combinational counter update between them.
//
// While an event waits on a stalled receiver, the next tick is still taken
// into the input register and waits there; in_ready then stays low until
// the event is taken. Ticks that make no event also need the result
// register free to advance. Reset (rst, synchronous) restores the register
// defaults (sustain 30, hold start 150, repeat 30), clears the key state to
// idle and empties both registers. The user must write configuration through
// cfg_we/cfg_index/cfg_data while the block is idle; it is not enforced.
module rf_key_press_hold_repeat_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   code_valid,
  input  logic [7:0]             rf_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             key_id,
  output logic [1:0]             event_kind,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [rfkp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rfkp_pkg::*;

  cfg_t    cfg;
  tick_t   tick_in, tick_held;
  logic    held_valid, out_free, advance;
  result_t result;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sustain_ticks <= SUSTAIN_RESET;
      cfg.hold_thresh   <= HOLD_START_RESET;
      cfg.repeat_ticks  <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SUSTAIN:    cfg.sustain_ticks <= cfg_data[SUSTAIN_W-1:0];
        CFG_HOLD_START: cfg.hold_thresh   <= cfg_data[HELD_W-1:0];
        CFG_REPEAT:     cfg.repeat_ticks  <= cfg_data[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_in.code_valid = code_valid;
  assign tick_in.rf_code    = rf_code;

  // A held tick is processed when the result register can take its outcome.
  assign advance = held_valid && out_free;

  rfkp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .tick_in    (tick_in),
    .advance    (advance),
    .held_valid (held_valid),
    .tick_held  (tick_held)
  );

  rfkp_tracker u_trk (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .tick   (tick_held),
    .result (result)
  );

  rfkp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result     (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .free       (out_free),
    .key_id     (key_id),
    .event_kind (event_kind)
  );

endmodule
